[rtl/detection_row_decoder_top_macros.svh]
// Assertion helpers for the checker file.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef DETECTION_ROW_DECODER_TOP_MACROS_SVH
`define DETECTION_ROW_DECODER_TOP_MACROS_SVH

// Check a property at every clock edge.
`define DRD_ASSERT_NOW(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define DRD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/drd_pkg.sv]
package drd_pkg;

    // Field and state widths
    localparam int VALUE_W   = 32;
    localparam int POS_W     = 10;
    localparam int BOX_WORDS = 4;
    localparam int BOX_IDX_W = 2;
    localparam int POS_SCORE = BOX_WORDS;
    localparam int POS_CLASS = BOX_WORDS + 1;
    localparam logic [POS_W-1:0] POS_MAX = 10'd1023;

    // Back end arithmetic widths: (word - pad) is 33 bits, inverse scale 25 bits signed
    localparam int DIFF_W = VALUE_W + 1;
    localparam int PROD_W = DIFF_W + 25;
    localparam int EXT_W  = PROD_W + 2;

    // Job queue, depth must be a power of two
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // Configuration port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        REG_EMBEDDED_MODE   = 3'd0,
        REG_CLASS_COUNT     = 3'd1,
        REG_SCORE_THRESHOLD = 3'd2,
        REG_INV_SCALE_X     = 3'd3,
        REG_INV_SCALE_Y     = 3'd4,
        REG_PAD_X           = 3'd5,
        REG_PAD_Y           = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic        embedded_mode;
        logic [7:0]  class_count;
        logic [16:0] score_threshold;
        logic [23:0] inv_scale_x;
        logic [23:0] inv_scale_y;
        logic [25:0] pad_x;
        logic [25:0] pad_y;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        embedded_mode:   1'b0,
        class_count:     8'd80,
        score_threshold: 17'd16384,
        inv_scale_x:     24'd65536,
        inv_scale_y:     24'd65536,
        pad_x:           26'd0,
        pad_y:           26'd0
    };

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last_in_row;
        logic                      first_of_frame;
    } elem_t;

    typedef struct packed {
        logic [7:0]                class_id;
        logic signed [VALUE_W-1:0] score;
        logic [15:0]               row_index;
        logic [14:0]               box_left;
        logic [14:0]               box_top;
        logic signed [15:0]        box_width;
        logic signed [15:0]        box_height;
    } det_t;

    // One qualifying row handed from the front end to the back end
    typedef struct packed {
        logic                                embedded_mode;
        logic [7:0]                          class_id;
        logic signed [VALUE_W-1:0]           score;
        logic [15:0]                         row_index;
        logic [BOX_WORDS-1:0][VALUE_W-1:0]   box_words;
    } job_t;

endpackage

[rtl/detection_row_decoder_top.sv]
// A row's job goes through the queue and the B_MUL and B_FIN states to det_reg.
// Throughput: one element per cycle while elem_stall is low; each detection
// passes the shared box multiplier, and every emitting row has at least 5 elements.
// A 4-entry job queue absorbs short bursts; elem_stall rises only when it is full.
// Reset: rst_n is asynchronous, active low; it clears row state, the queue and the
// output valid flag and loads the register defaults. No clearing pass is needed.
module detection_row_decoder_top
    import drd_pkg::*;
#(
    parameter int FRAC_BITS      = 16,
    parameter int ROW_COUNT_BITS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              elem_valid,
    output logic              elem_stall,
    input  elem_t             elem,
    output logic              det_valid,
    input  logic              det_stall,
    output det_t              det,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    cfg_t       cfg_reg;
    reg_index_t reg_index;
    logic       cfg_write;
    logic       push;
    job_t       push_job;
    logic       queue_full;
    logic       pop;
    job_t       head_job;
    logic       queue_not_empty;

    assign pready    = 1'b1;
    assign reg_index = reg_index_t'(paddr[ADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                REG_EMBEDDED_MODE:   cfg_reg.embedded_mode   <= pwdata[0];
                REG_CLASS_COUNT:     cfg_reg.class_count     <= pwdata[7:0];
                REG_SCORE_THRESHOLD: cfg_reg.score_threshold <= pwdata[16:0];
                REG_INV_SCALE_X:     cfg_reg.inv_scale_x     <= pwdata[23:0];
                REG_INV_SCALE_Y:     cfg_reg.inv_scale_y     <= pwdata[23:0];
                REG_PAD_X:           cfg_reg.pad_x           <= pwdata[25:0];
                REG_PAD_Y:           cfg_reg.pad_y           <= pwdata[25:0];
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    // Register reads
    always_comb
    begin
        unique case (reg_index)
            REG_EMBEDDED_MODE:   prdata = DATA_W'(cfg_reg.embedded_mode);
            REG_CLASS_COUNT:     prdata = DATA_W'(cfg_reg.class_count);
            REG_SCORE_THRESHOLD: prdata = DATA_W'(cfg_reg.score_threshold);
            REG_INV_SCALE_X:     prdata = DATA_W'(cfg_reg.inv_scale_x);
            REG_INV_SCALE_Y:     prdata = DATA_W'(cfg_reg.inv_scale_y);
            REG_PAD_X:           prdata = DATA_W'(cfg_reg.pad_x);
            REG_PAD_Y:           prdata = DATA_W'(cfg_reg.pad_y);
            default:             prdata = '0;
        endcase
    end

    drd_front #(
        .FRAC_BITS      (FRAC_BITS),
        .ROW_COUNT_BITS (ROW_COUNT_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .elem_valid (elem_valid),
        .elem_stall (elem_stall),
        .elem       (elem),
        .queue_full (queue_full),
        .push       (push),
        .push_job   (push_job)
    );

    drd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .full      (queue_full),
        .pop       (pop),
        .head_job  (head_job),
        .not_empty (queue_not_empty)
    );

    drd_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .not_empty (queue_not_empty),
        .head_job  (head_job),
        .pop       (pop),
        .det_valid (det_valid),
        .det_stall (det_stall),
        .det       (det)
    );

endmodule

[rtl/drd_queue.sv]
module drd_queue
    import drd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output job_t head_job,
    output logic not_empty
);

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              do_push;
    logic              do_pop;

    assign full      = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head_job  = entry_reg[rd_ptr_reg];

    // Store incoming jobs
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[rtl/drd_front.sv]
module drd_front
    import drd_pkg::*;
#(
    parameter int FRAC_BITS      = 16,
    parameter int ROW_COUNT_BITS = 16
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  logic  elem_valid,
    output logic  elem_stall,
    input  elem_t elem,
    input  logic  queue_full,
    output logic  push,
    output job_t  push_job
);

    logic [POS_W-1:0]                  pos_reg;
    logic [POS_W-1:0]                  pos_next;
    logic signed [VALUE_W-1:0]         best_score_reg;
    logic [7:0]                        best_class_reg;
    logic [ROW_COUNT_BITS-1:0]         row_cnt_reg;
    logic [ROW_COUNT_BITS-1:0]         row_cnt_next;
    logic [BOX_WORDS-1:0][VALUE_W-1:0] box_reg;

    logic                              accept;
    logic [POS_W-1:0]                  pos_cur;
    logic [POS_W-1:0]                  slot;
    logic signed [VALUE_W-1:0]         score_cur;
    logic signed [VALUE_W-1:0]         score_new;
    logic [7:0]                        class_cur;
    logic [7:0]                        class_new;
    logic [ROW_COUNT_BITS-1:0]         row_cur;
    logic signed [VALUE_W-1:0]         int_part;
    logic [7:0]                        class_of_value;
    logic                              score_ok;

    assign elem_stall = queue_full;
    assign accept     = elem_valid && !queue_full;

    // Integer part of the class element, clamped to 0..255
    assign int_part       = elem.value >>> FRAC_BITS;
    assign class_of_value = (elem.value < 0) ? 8'd0 :
                            ((int_part[VALUE_W-1:8] != '0) ? 8'hFF : int_part[7:0]);

    // Classify the element by its position in the row
    always_comb
    begin
        pos_cur   = elem.first_of_frame ? '0 : pos_reg;
        score_cur = elem.first_of_frame ? '0 : best_score_reg;
        class_cur = elem.first_of_frame ? '0 : best_class_reg;
        row_cur   = elem.first_of_frame ? '0 : row_cnt_reg;
        slot      = pos_cur - POS_W'(BOX_WORDS);
        score_new = score_cur;
        class_new = class_cur;
        if (pos_cur >= POS_W'(BOX_WORDS))
        begin
            if (cfg.embedded_mode)
            begin
                if (pos_cur == POS_W'(POS_SCORE))
                begin
                    score_new = elem.value;
                end
                else if (pos_cur == POS_W'(POS_CLASS))
                begin
                    class_new = class_of_value;
                end
            end
            else if (slot < POS_W'(cfg.class_count))
            begin
                if (pos_cur == POS_W'(POS_SCORE) || elem.value > score_cur)
                begin
                    score_new = elem.value;
                    class_new = slot[7:0];
                end
            end
        end
    end

    // Hand a qualifying row to the back end
    assign score_ok = $signed({score_new[VALUE_W-1], score_new}) >=
                      $signed({16'd0, cfg.score_threshold});
    assign push     = accept && elem.last_in_row && (pos_cur >= POS_W'(BOX_WORDS)) && score_ok;

    always_comb
    begin
        push_job.embedded_mode = cfg.embedded_mode;
        push_job.class_id      = class_new;
        push_job.score         = score_new;
        push_job.row_index     = 16'(row_cur);
        push_job.box_words     = box_reg;
    end

    // Row position and row numbering
    always_comb
    begin
        if (elem.last_in_row)
        begin
            pos_next     = '0;
            row_cnt_next = row_cur + 1'b1;
        end
        else
        begin
            pos_next     = (pos_cur < POS_MAX) ? pos_cur + 1'b1 : pos_cur;
            row_cnt_next = row_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            best_score_reg <= '0;
            best_class_reg <= '0;
            row_cnt_reg    <= '0;
        end
        else if (accept)
        begin
            pos_reg     <= pos_next;
            row_cnt_reg <= row_cnt_next;
            if (elem.last_in_row)
            begin
                best_score_reg <= '0;
                best_class_reg <= '0;
            end
            else
            begin
                best_score_reg <= score_new;
                best_class_reg <= class_new;
            end
        end
    end

    // Capture box words at the start of a row
    always_ff @(posedge clk)
    begin
        if (accept && (pos_cur < POS_W'(BOX_WORDS)))
        begin
            box_reg[pos_cur[BOX_IDX_W-1:0]] <= elem.value;
        end
    end

endmodule

[rtl/drd_back.sv]
module drd_back
    import drd_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic not_empty,
    input  job_t head_job,
    output logic pop,
    output logic det_valid,
    input  logic det_stall,
    output det_t det
);

    localparam int SH = 2 * FRAC_BITS;
    localparam logic signed [EXT_W-1:0] HALF    = EXT_W'(1) << (SH - 1);
    localparam logic signed [EXT_W-1:0] ONE     = EXT_W'(1) << SH;
    localparam logic signed [EXT_W-1:0] PIX_MAX = EXT_W'(32767);
    localparam logic signed [EXT_W-1:0] S16_MAX = EXT_W'(32767);
    localparam logic signed [EXT_W-1:0] S16_MIN = -EXT_W'(32768);

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_MUL  = 3'b010,
        B_FIN  = 3'b100
    } back_state_t;

    back_state_t               state_reg;
    back_state_t               state_next;
    logic [BOX_IDX_W-1:0]      step_reg;
    logic [BOX_IDX_W-1:0]      step_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    det_t                      det_reg;

    logic signed [DIFF_W-1:0]  diff_reg [BOX_WORDS];
    logic signed [DIFF_W-1:0]  diff_next [BOX_WORDS];
    logic signed [PROD_W-1:0]  prod_reg [BOX_WORDS];
    logic                      emb_reg;
    logic [7:0]                class_reg;
    logic signed [VALUE_W-1:0] score_reg;
    logic [15:0]               row_reg;

    logic                      out_free;
    logic                      load_out;
    logic [25:0]               pad_k;
    logic [23:0]               inv_sel;
    logic signed [24:0]        mul_b;
    logic signed [DIFF_W-1:0]  mul_a;
    logic signed [PROD_W-1:0]  mul_p;

    logic signed [EXT_W-1:0]   rnd [BOX_WORDS];
    logic signed [EXT_W-1:0]   sum_k;
    logic signed [EXT_W-1:0]   edge_sum_x;
    logic signed [EXT_W-1:0]   edge_sum_y;
    logic signed [EXT_W-1:0]   edge_x;
    logic signed [EXT_W-1:0]   edge_y;
    logic [14:0]               corner [BOX_WORDS];
    det_t                      det_calc;

    function automatic logic signed [EXT_W-1:0] ext_prod(input logic signed [PROD_W-1:0] p);
        ext_prod = {{(EXT_W-PROD_W){p[PROD_W-1]}}, p};
    endfunction

    function automatic logic [14:0] clamp_pix(input logic signed [EXT_W-1:0] v);
        if (v < 0)
        begin
            clamp_pix = '0;
        end
        else if (v > PIX_MAX)
        begin
            clamp_pix = 15'h7FFF;
        end
        else
        begin
            clamp_pix = v[14:0];
        end
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [EXT_W-1:0] v);
        if (v > S16_MAX)
        begin
            sat16 = 16'sh7FFF;
        end
        else if (v < S16_MIN)
        begin
            sat16 = 16'sh8000;
        end
        else
        begin
            sat16 = v[15:0];
        end
    endfunction

    assign out_free  = !out_valid_reg || !det_stall;
    assign load_out  = (state_reg == B_FIN) && out_free;
    assign pop       = not_empty && ((state_reg == B_IDLE) || load_out);
    assign det_valid = out_valid_reg;
    assign det       = det_reg;

    // Subtract letterbox pad from head job words 0-1, in embedded mode also 2-3
    always_comb
    begin
        pad_k = '0;
        for (int k = 0; k < BOX_WORDS; k++)
        begin
            if (k >= 2 && !head_job.embedded_mode)
            begin
                pad_k = '0;
            end
            else
            begin
                pad_k = k[0] ? cfg.pad_y : cfg.pad_x;
            end
            diff_next[k] = $signed({head_job.box_words[k][VALUE_W-1], head_job.box_words[k]})
                         - $signed({7'd0, pad_k});
        end
    end

    // Shared multiplier, one box word per cycle
    assign inv_sel = step_reg[0] ? cfg.inv_scale_y : cfg.inv_scale_x;
    assign mul_b   = $signed({1'b0, inv_sel});
    assign mul_a   = diff_reg[step_reg];
    assign mul_p   = mul_a * mul_b;

    // Round, convert and clamp the four products
    always_comb
    begin
        sum_k = '0;
        for (int k = 0; k < BOX_WORDS; k++)
        begin
            sum_k     = ext_prod(prod_reg[k]) + HALF;
            rnd[k]    = sum_k >>> SH;
            corner[k] = clamp_pix(rnd[k]);
        end
        edge_sum_x = (ext_prod(prod_reg[0]) <<< 1) - ext_prod(prod_reg[2]) + ONE;
        edge_sum_y = (ext_prod(prod_reg[1]) <<< 1) - ext_prod(prod_reg[3]) + ONE;
        edge_x     = edge_sum_x >>> (SH + 1);
        edge_y     = edge_sum_y >>> (SH + 1);

        det_calc.class_id  = class_reg;
        det_calc.score     = score_reg;
        det_calc.row_index = row_reg;
        if (emb_reg)
        begin
            det_calc.box_left   = corner[0];
            det_calc.box_top    = corner[1];
            det_calc.box_width  = $signed({1'b0, corner[2]}) - $signed({1'b0, corner[0]});
            det_calc.box_height = $signed({1'b0, corner[3]}) - $signed({1'b0, corner[1]});
        end
        else
        begin
            det_calc.box_left   = clamp_pix(edge_x);
            det_calc.box_top    = clamp_pix(edge_y);
            det_calc.box_width  = sat16(rnd[2]);
            det_calc.box_height = sat16(rnd[3]);
        end
    end

    // Sequencer: load a job, multiply four words, finish into the output register
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = load_out || (out_valid_reg && det_stall);
        unique case (state_reg)
            B_IDLE:
            begin
                if (pop)
                begin
                    state_next = B_MUL;
                    step_next  = '0;
                end
            end
            B_MUL:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == BOX_IDX_W'(BOX_WORDS - 1))
                begin
                    state_next = B_FIN;
                end
            end
            B_FIN:
            begin
                if (load_out)
                begin
                    step_next  = '0;
                    state_next = pop ? B_MUL : B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold job data, products and the finished result
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            for (int k = 0; k < BOX_WORDS; k++)
            begin
                diff_reg[k] <= diff_next[k];
            end
            emb_reg   <= head_job.embedded_mode;
            class_reg <= head_job.class_id;
            score_reg <= head_job.score;
            row_reg   <= head_job.row_index;
        end
        if (state_reg == B_MUL)
        begin
            prod_reg[step_reg] <= mul_p;
        end
        if (load_out)
        begin
            det_reg <= det_calc;
        end
    end

endmodule

[rtl/drd_checker.sv]
`include "detection_row_decoder_top_macros.svh"

module drd_checker
    import drd_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  elem_valid,
    input logic  elem_stall,
    input logic  det_valid,
    input logic  det_stall,
    input det_t  det
);

    // A stalled result holds its value
    `DRD_ASSERT_NEXT(a_det_hold, det_valid && det_stall, det_valid && $stable(det), "stalled result changed")

    // The queue fills only right after an accepted element
    `DRD_ASSERT_NOW(a_stall_cause, $rose(elem_stall) |-> $past(elem_valid && !elem_stall), "stall rose without an accepted element")

    // Back-to-back results are not followed by a third
    `DRD_ASSERT_NEXT(a_det_spacing, (det_valid && !det_stall) ##1 (det_valid && !det_stall), !det_valid, "results closer than the back end allows")

endmodule

bind detection_row_decoder_top drd_checker u_checker (.*);

[bench/detection_row_decoder_checker.sv]
`timescale 1ns / 1ps

module detection_row_decoder_checker
    import drd_pkg::*;
#(
    parameter int FRAC_BITS      = 16,
    parameter int ROW_COUNT_BITS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              elem_valid,
    input  logic              elem_stall,
    input  elem_t             elem,
    input  logic              det_valid,
    input  logic              det_stall,
    input  det_t              det,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    input  logic              pready,
    output int                fail_count,
    output int                pending_count,
    output int                detections_seen
);

    localparam int     PROD_SHIFT = 2 * FRAC_BITS;
    localparam longint HALF_PIXEL = longint'(1) << (PROD_SHIFT - 1);
    localparam longint ROW_MASK   = (longint'(1) << ROW_COUNT_BITS) - 1;

    // Register copy and row state of the decoder
    cfg_t        regs;
    int unsigned elem_pos;
    longint      best_score;
    logic [7:0]  best_class;
    longint      box_word [BOX_WORDS];
    longint      row_num;

    det_t        expected_dets [$];
    int          errors = 0;
    int          matched = 0;

    function automatic longint clamp_to(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // (v - pad) * inv rounded half up to whole pixels
    function automatic longint unscale_px(longint v, longint pad, longint inv);
        return ((v - pad) * inv + HALF_PIXEL) >>> PROD_SHIFT;
    endfunction

    // Edge from center and size: floor(c - w/2 + 0.5)
    function automatic longint edge_px(longint cv, longint wv, longint pad, longint inv);
        longint c;
        longint w;
        c = (cv - pad) * inv;
        w = wv * inv;
        return (2 * c - w + (longint'(1) << PROD_SHIFT)) >>> (PROD_SHIFT + 1);
    endfunction

    function automatic longint size_px(longint wv, longint inv);
        return (wv * inv + HALF_PIXEL) >>> PROD_SHIFT;
    endfunction

    // Integer part toward zero, clamped to a byte
    function automatic logic [7:0] class_from(longint v);
        longint c;
        if (v < 0)
        begin
            return 8'd0;
        end
        c = clamp_to(v >>> FRAC_BITS, 0, 255);
        return c[7:0];
    endfunction

    function automatic det_t row_detection();
        det_t   d;
        longint px;
        longint py;
        longint ix;
        longint iy;
        longint left;
        longint top;
        longint width;
        longint height;
        px = longint'(regs.pad_x);
        py = longint'(regs.pad_y);
        ix = longint'(regs.inv_scale_x);
        iy = longint'(regs.inv_scale_y);
        if (regs.embedded_mode)
        begin
            left   = clamp_to(unscale_px(box_word[0], px, ix), 0, 32767);
            top    = clamp_to(unscale_px(box_word[1], py, iy), 0, 32767);
            width  = clamp_to(unscale_px(box_word[2], px, ix), 0, 32767) - left;
            height = clamp_to(unscale_px(box_word[3], py, iy), 0, 32767) - top;
        end
        else
        begin
            left   = clamp_to(edge_px(box_word[0], box_word[2], px, ix), 0, 32767);
            top    = clamp_to(edge_px(box_word[1], box_word[3], py, iy), 0, 32767);
            width  = clamp_to(size_px(box_word[2], ix), -32768, 32767);
            height = clamp_to(size_px(box_word[3], iy), -32768, 32767);
        end
        d.class_id   = best_class;
        d.score      = best_score[31:0];
        d.row_index  = row_num[15:0];
        d.box_left   = left[14:0];
        d.box_top    = top[14:0];
        d.box_width  = width[15:0];
        d.box_height = height[15:0];
        return d;
    endfunction

    task automatic start_row();
        elem_pos   = 0;
        best_score = 0;
        best_class = 8'd0;
    endtask

    // Advance the row state by one element and queue any detection it closes
    task automatic take_element(input elem_t e);
        longint      v;
        int unsigned p;
        v = longint'($signed(e.value));
        if (e.first_of_frame)
        begin
            row_num = 0;
            start_row();
        end
        p = elem_pos;
        if (p < BOX_WORDS)
        begin
            box_word[p] = v;
        end
        else if (regs.embedded_mode)
        begin
            if (p == POS_SCORE)
                best_score = v;
            else if (p == POS_CLASS)
                best_class = class_from(v);
        end
        else if (p - BOX_WORDS < regs.class_count)
        begin
            if (p == POS_SCORE || v > best_score)
            begin
                best_score = v;
                best_class = 8'(p - BOX_WORDS);
            end
        end
        if (e.last_in_row)
        begin
            if (p >= BOX_WORDS && best_score >= longint'(regs.score_threshold))
                expected_dets.push_back(row_detection());
            row_num = (row_num + 1) & ROW_MASK;
            start_row();
        end
        else if (p < POS_MAX)
        begin
            elem_pos = p + 1;
        end
    endtask

    task automatic report_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Compare one detection against the oldest prediction
    task automatic check_detection(input det_t got);
        det_t want;
        if (expected_dets.size() == 0)
        begin
            errors++;
            $display("%0t: detection with none expected, expected nothing, actual class %0d score %0d row %0d",
                     $time, got.class_id, $signed(got.score), got.row_index);
        end
        else
        begin
            want = expected_dets.pop_front();
            report_field("class_id", want.class_id, got.class_id);
            report_field("score", $signed(want.score), $signed(got.score));
            report_field("row_index", want.row_index, got.row_index);
            report_field("box_left", want.box_left, got.box_left);
            report_field("box_top", want.box_top, got.box_top);
            report_field("box_width", $signed(want.box_width), $signed(got.box_width));
            report_field("box_height", $signed(want.box_height), $signed(got.box_height));
            matched++;
        end
    endtask

    // Track register writes, check results, then predict from requests
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs = CFG_RESET;
            start_row();
            for (int i = 0; i < BOX_WORDS; i++)
                box_word[i] = 0;
            row_num = 0;
            expected_dets.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_index_t'(paddr[ADDR_W-1:2]))
                    REG_EMBEDDED_MODE:   regs.embedded_mode   = pwdata[0];
                    REG_CLASS_COUNT:     regs.class_count     = pwdata[7:0];
                    REG_SCORE_THRESHOLD: regs.score_threshold = pwdata[16:0];
                    REG_INV_SCALE_X:     regs.inv_scale_x     = pwdata[23:0];
                    REG_INV_SCALE_Y:     regs.inv_scale_y     = pwdata[23:0];
                    REG_PAD_X:           regs.pad_x           = pwdata[25:0];
                    REG_PAD_Y:           regs.pad_y           = pwdata[25:0];
                    default: ;
                endcase
            end
            if (det_valid && !det_stall)
                check_detection(det);
            if (elem_valid && !elem_stall)
                take_element(elem);
        end
        pending_count   <= expected_dets.size();
        fail_count      <= errors;
        detections_seen <= matched;
    end

endmodule

[bench/detection_row_decoder_top_test.sv]
`timescale 1ns / 1ps

module detection_row_decoder_top_test;
    import drd_pkg::*;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              elem_valid;
    logic              elem_stall;
    elem_t             elem;
    logic              det_valid;
    logic              det_stall;
    det_t              det;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int fail_count;
    int pending_count;
    int detections_seen;

    // Stimulus control
    int send_idle_pct = 0;
    int recv_idle_pct;
    int hold_requests;
    int elements_sent = 0;
    int settings_used = 0;

    // What the current register setting means for row building
    logic embedded_on = 1'b0;
    int   class_cnt = 80;
    int   thr = 16384;

    logic signed [31:0] row_vals [$];

    detection_row_decoder_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .elem_valid (elem_valid),
        .elem_stall (elem_stall),
        .elem       (elem),
        .det_valid  (det_valid),
        .det_stall  (det_stall),
        .det        (det),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    detection_row_decoder_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .elem_valid      (elem_valid),
        .elem_stall      (elem_stall),
        .elem            (elem),
        .det_valid       (det_valid),
        .det_stall       (det_stall),
        .det             (det),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .fail_count      (fail_count),
        .pending_count   (pending_count),
        .detections_seen (detections_seen)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Result side: random stall, or a long hold-off when one is requested
    initial
    begin
        int holds_done;
        int hold_left;
        holds_done = 0;
        hold_left = 0;
        det_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_done)
            begin
                holds_done++;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                det_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                det_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    initial
    begin
        #4000000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic write_config(input reg_index_t idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one element after a random gap and hold it until taken
    task automatic send_elem(input logic signed [31:0] v, input logic last, input logic restart);
        while ($urandom_range(99) < send_idle_pct)
        begin
            elem_valid <= 1'b0;
            @(posedge clk);
        end
        elem_valid           <= 1'b1;
        elem.value           <= v;
        elem.last_in_row     <= last;
        elem.first_of_frame  <= restart;
        @(posedge clk);
        while (elem_stall)
            @(posedge clk);
        elements_sent++;
    endtask

    task automatic send_row(input int restart_at);
        for (int i = 0; i < row_vals.size(); i++)
            send_elem(row_vals[i], i == row_vals.size() - 1, i == restart_at);
    endtask

    // Drop valid and wait until every predicted detection has come out
    task automatic wait_idle();
        elem_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    function automatic logic signed [31:0] coord_word();
        case ($urandom_range(9))
            0:
            begin
                case ($urandom_range(3))
                    0:       return 32'sh7FFFFFFF;
                    1:       return 32'sh80000000;
                    2:       return 32'sh00000000;
                    default: return 32'shFFFFFFFF;
                endcase
            end
            1, 2:    return $urandom;
            default: return $signed($urandom_range(0, 900 << 16)) - (64 << 16);
        endcase
    endfunction

    function automatic logic signed [31:0] size_word();
        case ($urandom_range(9))
            0:       return $urandom;
            1:       return -$signed($urandom_range(0, 50 << 16));
            default: return $urandom_range(0, 500 << 16);
        endcase
    endfunction

    // Scores cluster around the threshold so about half the rows emit
    function automatic logic signed [31:0] score_word();
        case ($urandom_range(9))
            0, 1, 2, 3: return thr + $urandom_range(0, 8192) - 4096;
            4:          return thr;
            5:          return thr - 1;
            6, 7:       return $urandom;
            default:    return $urandom_range(0, 2 << 16);
        endcase
    endfunction

    function automatic logic signed [31:0] class_word();
        case ($urandom_range(5))
            0:       return $urandom;
            1:       return -$signed($urandom_range(0, 10 << 16));
            2:       return 32'sh012C0000;
            default: return ($urandom_range(0, 90) << 16) | $urandom_range(0, 65535);
        endcase
    endfunction

    function automatic void build_plain_row();
        row_vals.delete();
        row_vals.push_back(coord_word());
        row_vals.push_back(coord_word());
        row_vals.push_back(size_word());
        row_vals.push_back(size_word());
        for (int c = 0; c < class_cnt; c++)
        begin
            // repeat a score now and then to exercise first-max ties
            if (c > 0 && $urandom_range(7) == 0)
                row_vals.push_back(row_vals[row_vals.size() - 1]);
            else
                row_vals.push_back(score_word());
        end
        repeat ($urandom_range(0, 6)) row_vals.push_back($urandom);
    endfunction

    function automatic void build_embedded_row(input bit with_class);
        row_vals.delete();
        repeat (4) row_vals.push_back(coord_word());
        row_vals.push_back(score_word());
        if (with_class || $urandom_range(9) != 0)
        begin
            row_vals.push_back(class_word());
            repeat ($urandom_range(0, 6)) row_vals.push_back($urandom);
        end
    endfunction

    task automatic apply_setting(input int k);
        logic        m;
        int          cc;
        int          th;
        logic [31:0] ix;
        logic [31:0] iy;
        logic [31:0] px;
        logic [31:0] py;
        th = $urandom_range(0, 65536);
        ix = $urandom_range(16384, 262144);
        iy = $urandom_range(16384, 262144);
        px = $urandom_range(0, 80 << 16);
        py = $urandom_range(0, 80 << 16);
        case (k)
            0:
            begin
                m = 1'b0; cc = 1; th = 0; ix = 1; iy = 1;
                px = 32'h3FFFFFF; py = 32'h3FFFFFF;
            end
            1:
            begin
                m = 1'b0; cc = 255; th = 65536; ix = 32'hFFFFFF; iy = 32'hFFFFFF;
                px = 0; py = 0;
            end
            2:
            begin
                m = 1'b0; cc = 0; th = 0;
            end
            3:
            begin
                m = 1'b0; cc = $urandom_range(2, 12);
            end
            4:
            begin
                m = 1'b1; cc = $urandom_range(1, 255);
                ix = $urandom_range(1, 32'hFFFFFF); iy = $urandom_range(1, 32'hFFFFFF);
                px = $urandom & 32'h3FFFFFF; py = $urandom & 32'h3FFFFFF;
            end
            5:
            begin
                // zero scale collapses every box to the origin
                m = 1'b1; cc = 80; th = 0; ix = 0; iy = 0;
                px = $urandom & 32'h3FFFFFF; py = $urandom & 32'h3FFFFFF;
            end
            default:
            begin
                m = 1'b1; cc = $urandom_range(1, 255);
            end
        endcase
        write_config(REG_EMBEDDED_MODE, {31'd0, m});
        write_config(REG_CLASS_COUNT, cc);
        write_config(REG_SCORE_THRESHOLD, th);
        write_config(REG_INV_SCALE_X, ix);
        write_config(REG_INV_SCALE_Y, iy);
        write_config(REG_PAD_X, px);
        write_config(REG_PAD_Y, py);
        embedded_on = m;
        class_cnt = cc;
        thr = th;
        settings_used++;
    endtask

    initial
    begin
        int r;
        int cut;
        int sent_before;
        rst_n         <= 1'b0;
        elem_valid    <= 1'b0;
        elem          <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        hold_requests <= 0;
        recv_idle_pct <= 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Plain mode, three classes, everything non-negative passes
        write_config(REG_EMBEDDED_MODE, 0);
        write_config(REG_CLASS_COUNT, 3);
        write_config(REG_SCORE_THRESHOLD, 0);
        write_config(REG_INV_SCALE_X, 65536);
        write_config(REG_INV_SCALE_Y, 65536);
        write_config(REG_PAD_X, 0);
        write_config(REG_PAD_Y, 0);
        settings_used++;
        // extreme box words, tied maximum keeps the first class
        row_vals = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000,
                     32'shFFFD0000, 32'sh00070000, 32'sh00070000};
        send_row(0);
        // row ending before the score emits nothing
        row_vals = '{32'sh00640000, 32'sh00C80000};
        send_row(-1);
        // row cut short after one negative score
        row_vals = '{32'sh01000000, 32'sh00800000, 32'sh00200000, 32'sh00100000,
                     32'shFFFFFFFF};
        send_row(-1);

        // Embedded mode, score exactly at the top threshold, class saturates
        wait_idle();
        write_config(REG_EMBEDDED_MODE, 1);
        write_config(REG_SCORE_THRESHOLD, 65536);
        write_config(REG_INV_SCALE_X, 0);
        write_config(REG_INV_SCALE_Y, 32'hFFFFFF);
        write_config(REG_PAD_X, 32'h3FFFFFF);
        write_config(REG_PAD_Y, 0);
        settings_used++;
        row_vals = '{32'sh00640000, 32'shFFFB0000, 32'sh7FFFFFFF, 32'sh80000000,
                     32'sh00010000, 32'sh012C0000};
        send_row(-1);
        // no class element: class stays zero
        row_vals = '{32'sh00280000, 32'sh00300000, 32'sh01400000, 32'sh00F00000,
                     32'sh7FFFFFFF};
        send_row(-1);

        // Random rows under every setting, with three idling patterns
        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 26;
                    recv_idle_pct <= 87;
                end
                1:
                begin
                    send_idle_pct = 87;
                    recv_idle_pct <= 26;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct <= 0;
                end
            endcase
            for (int k = 0; k < 7; k++)
            begin
                wait_idle();
                apply_setting(k);
                sent_before = elements_sent;
                while (elements_sent - sent_before < 85)
                begin
                    r = $urandom_range(99);
                    if (r < 82)
                    begin
                        if (embedded_on)
                            build_embedded_row(1'b0);
                        else
                            build_plain_row();
                        send_row(($urandom_range(15) == 0) ? 0 : -1);
                    end
                    else if (r < 91)
                    begin
                        row_vals.delete();
                        repeat ($urandom_range(1, 4)) row_vals.push_back($urandom);
                        send_row(-1);
                    end
                    else
                    begin
                        // broken row: truncated, restarted somewhere inside
                        if (embedded_on)
                            build_embedded_row(1'b0);
                        else
                            build_plain_row();
                        cut = $urandom_range(1, row_vals.size());
                        while (row_vals.size() > cut)
                            void'(row_vals.pop_back());
                        send_row($urandom_range(0, cut - 1));
                    end
                end
            end
        end

        // Hold off results long enough for the job queue to fill
        wait_idle();
        apply_setting(5);
        hold_requests <= hold_requests + 1;
        repeat (16)
        begin
            build_embedded_row(1'b1);
            row_vals[4] = $urandom_range(0, 1 << 20);
            send_row(-1);
        end

        // Row longer than the position counter can count
        wait_idle();
        apply_setting(6);
        build_embedded_row(1'b1);
        row_vals[4] = thr + $urandom_range(0, 1000);
        while (row_vals.size() < 1030)
            row_vals.push_back($urandom);
        send_row(0);

        // Walk the row counter through its wrap with one-element rows
        wait_idle();
        apply_setting(0);
        build_plain_row();
        row_vals[4] = 32'sh00010000;
        send_row(0);
        repeat (65534) send_elem($urandom, 1'b1, 1'b0);
        repeat (2)
        begin
            build_plain_row();
            row_vals[4] = 32'sh00010000;
            send_row(-1);
        end

        wait_idle();
        repeat (8) @(posedge clk);
        $display("Run covered %0d row elements and %0d checked detections over %0d settings,",
                 elements_sent, detections_seen, settings_used);
        $display("including a long result hold-off, a 1030-element row and a row counter wrap.");
        if (fail_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/drd_pkg.sv
rtl/drd_queue.sv
rtl/drd_front.sv
rtl/drd_back.sv
rtl/detection_row_decoder_top.sv
rtl/drd_checker.sv
bench/detection_row_decoder_checker.sv
bench/detection_row_decoder_top_test.sv
